>>> rtl/nearest_neighbor_resampler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor resampler
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_RESAMPLER_UNIT_MACROS_SVH
`define NEAREST_NEIGHBOR_RESAMPLER_UNIT_MACROS_SVH

// Check a condition at every clock edge.
`define NNR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after the antecedent.
`define NNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nnr_pkg.sv
// ----------------------------------------------------------------------------
// nnr_pkg
// Types and constants for the nearest-neighbor resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nnr_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_RUN     = 64;
  localparam int unsigned RUN_CNT_W   = $clog2(MAX_RUN + 1);
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  // ceil(2^32 / MAX_RUN): smallest step allowed while interpolating
  localparam logic [63:0] MIN_STEP_WIDE =
    ((64'd1 << 32) + 64'(MAX_RUN) - 64'd1) / 64'(MAX_RUN);
  localparam logic [PHASE_W-1:0] MIN_INTERP_STEP = MIN_STEP_WIDE[PHASE_W-1:0];

  // register indexes (byte address 4*index)
  localparam logic REG_INTERPOLATE_MODE = 1'b0;
  localparam logic REG_PHASE_STEP       = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_real;
    logic signed [SAMPLE_BITS-1:0] in_imag;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_real;
    logic signed [SAMPLE_BITS-1:0] out_imag;
    logic                          last_of_run;
  } out_beat_t;

  typedef enum logic {
    NNR_IDLE,
    NNR_STEP
  } nnr_state_e;

endpackage

>>> rtl/nearest_neighbor_resampler_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_resampler_unit: phase-accumulator nearest-neighbor resampler
// Decimate: one input beat per cycle while the output slot is free; its result (if any) appears in the cycle after.
// Interpolate: an accept, then sequencer steps of the accumulator through
//   the shared 32-bit adder until a wrap or the run cap ends the run, with
//   output stalls holding the sequencer; no new sample is taken meanwhile.
// Reset: asynchronous; control, config and accumulator state cleared to zero,
//   payload registers not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_neighbor_resampler_unit_macros.svh"

module nearest_neighbor_resampler_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input sample channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  nnr_pkg::in_beat_t                  in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output nnr_pkg::out_beat_t                 out_data_o,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nnr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [nnr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nnr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                          mode_q, mode_d;
  logic [nnr_pkg::PHASE_W-1:0]   step_q, step_d;
  logic                          cfg_wr;
  logic                          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_comb begin
    mode_d = mode_q;
    step_d = step_q;
    if (cfg_wr) begin
      case (cfg_idx)
        nnr_pkg::REG_INTERPOLATE_MODE: mode_d = pwdata[0];
        nnr_pkg::REG_PHASE_STEP:       step_d = pwdata[nnr_pkg::PHASE_W-1:0];
        default:                       mode_d = mode_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      nnr_pkg::REG_INTERPOLATE_MODE: prdata = {{(nnr_pkg::APB_DATA_W-1){1'b0}}, mode_q};
      nnr_pkg::REG_PHASE_STEP:       prdata = step_q;
      default:                       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath state
  // --------------------------------------------------------------------------
  nnr_pkg::nnr_state_e            state_q, state_d;
  logic [nnr_pkg::PHASE_W-1:0]    phase_acc_q, phase_acc_d;
  logic [nnr_pkg::PHASE_W-1:0]    prev_phase_q, prev_phase_d;
  logic                           wrap_pending_q, wrap_pending_d;
  // results already decided for the current item; the newest one is held
  // back until the next step tells whether it ends the run
  logic [nnr_pkg::RUN_CNT_W-1:0]  n_q, n_d;
  nnr_pkg::in_beat_t              sample_q, sample_d;
  logic                           out_valid_q, out_valid_d;
  nnr_pkg::out_beat_t             out_q, out_d;

  logic                           in_fire;
  logic                           slot_free;
  logic [nnr_pkg::PHASE_W-1:0]    step_sel;
  logic [nnr_pkg::PHASE_W-1:0]    phase_sum;
  logic                           wrap;
  logic                           run_full;
  logic                           run_done;

  // The output register frees when empty or when its beat is taken now.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == nnr_pkg::NNR_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Shared unit: one 32-bit adder and wrap compare, used once per item in
  // decimate mode and once per step in interpolate mode.
  always_comb begin
    step_sel = step_q;
    if (mode_q && (step_q < nnr_pkg::MIN_INTERP_STEP)) begin
      step_sel = nnr_pkg::MIN_INTERP_STEP;
    end
  end

  assign phase_sum = phase_acc_q + step_sel;
  assign wrap      = (phase_sum <= phase_acc_q);
  assign run_full  = (n_q == nnr_pkg::RUN_CNT_W'(nnr_pkg::MAX_RUN));
  assign run_done  = run_full || wrap;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nnr_pkg::NNR_IDLE: begin
        if (in_fire && mode_q) begin
          state_d = nnr_pkg::NNR_STEP;
        end
      end
      nnr_pkg::NNR_STEP: begin
        if (slot_free && run_done) begin
          state_d = nnr_pkg::NNR_IDLE;
        end
      end
      default: state_d = nnr_pkg::NNR_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    phase_acc_d    = phase_acc_q;
    prev_phase_d   = prev_phase_q;
    wrap_pending_d = wrap_pending_q;
    n_d            = n_q;
    sample_d       = sample_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && !out_ready_i;

    case (state_q)
      nnr_pkg::NNR_IDLE: begin
        if (in_fire) begin
          if (!mode_q) begin
            // Decimate: pass the sample on when the last step did not grow,
            // drop any owed wrap result, then advance once.
            wrap_pending_d = 1'b0;
            if (phase_acc_q <= prev_phase_q) begin
              out_d.out_real    = in_data_i.in_real;
              out_d.out_imag    = in_data_i.in_imag;
              out_d.last_of_run = 1'b1;
              out_valid_d       = 1'b1;
            end
            prev_phase_d = phase_acc_q;
            phase_acc_d  = phase_sum;
          end else begin
            // Interpolate: an owed wrap result counts as the first one.
            sample_d = in_data_i;
            if (wrap_pending_q) begin
              n_d            = nnr_pkg::RUN_CNT_W'(1);
              wrap_pending_d = 1'b0;
            end else begin
              n_d = '0;
            end
          end
        end
      end

      nnr_pkg::NNR_STEP: begin
        // Hold everything while the output register is still occupied.
        if (slot_free) begin
          out_d.out_real = sample_q.in_real;
          out_d.out_imag = sample_q.in_imag;
          if (run_full) begin
            // run cap reached: no further step, release the held result
            out_d.last_of_run = 1'b1;
            out_valid_d       = 1'b1;
          end else begin
            prev_phase_d = phase_acc_q;
            phase_acc_d  = phase_sum;
            if (wrap) begin
              // the wrap result belongs to the next item
              wrap_pending_d = 1'b1;
              if (n_q != '0) begin
                out_d.last_of_run = 1'b1;
                out_valid_d       = 1'b1;
              end
            end else begin
              if (n_q != '0) begin
                out_d.last_of_run = 1'b0;
                out_valid_d       = 1'b1;
              end
              n_d = n_q + nnr_pkg::RUN_CNT_W'(1);
            end
          end
        end
      end

      default: begin
        n_d = '0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= 1'b0;
      step_q         <= '0;
      state_q        <= nnr_pkg::NNR_IDLE;
      phase_acc_q    <= '0;
      prev_phase_q   <= '0;
      wrap_pending_q <= 1'b0;
      n_q            <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      mode_q         <= mode_d;
      step_q         <= step_d;
      state_q        <= state_d;
      phase_acc_q    <= phase_acc_d;
      prev_phase_q   <= prev_phase_d;
      wrap_pending_q <= wrap_pending_d;
      n_q            <= n_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    out_q    <= out_d;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `NNR_ASSERT(a_ready_only_idle, !in_ready_o || (state_q == nnr_pkg::NNR_IDLE), "ready while busy")
  `NNR_ASSERT(a_run_bound, n_q <= nnr_pkg::RUN_CNT_W'(nnr_pkg::MAX_RUN), "run count overflow")
  `NNR_ASSERT(a_step_interp, (state_q != nnr_pkg::NNR_STEP) || mode_q, "stepping in decimate mode")
  `NNR_ASSERT_NEXT(a_dec_clears, in_fire && !mode_q, !wrap_pending_q, "pending kept by decimate")

endmodule

>>> tb/nearest_neighbor_resampler_checker.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_resampler_checker
// Snoops the APB writes, the sample channel and the result channel of the
// resampler. Keeps its own accumulator and register copy, predicts the
// result beats of every accepted sample and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_neighbor_resampler_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               sample_valid_i,
  input  logic                               sample_ready_i,
  input  nnr_pkg::in_beat_t                  sample_data_i,
  input  logic                               result_valid_i,
  input  logic                               result_ready_i,
  input  nnr_pkg::out_beat_t                 result_data_i,
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic                               pready_i,
  input  logic [nnr_pkg::APB_ADDR_W-1:0]     paddr_i,
  input  logic [nnr_pkg::APB_DATA_W-1:0]     pwdata_i,
  output int unsigned                        error_count_o,
  output int unsigned                        outstanding_o
);

  localparam int unsigned MAX_REPORTS = 10;
  // smallest step the interpolator will use: ceil(2^32 / MAX_RUN)
  localparam logic [63:0] FLOOR_WIDE =
    ((64'd1 << nnr_pkg::PHASE_W) + 64'(nnr_pkg::MAX_RUN) - 64'd1) / 64'(nnr_pkg::MAX_RUN);
  localparam logic [nnr_pkg::PHASE_W-1:0] STEP_FLOOR = nnr_pkg::PHASE_W'(FLOOR_WIDE);

  logic                         interp_q;
  logic [nnr_pkg::PHASE_W-1:0]  step_q;
  logic [nnr_pkg::PHASE_W-1:0]  acc_q;
  logic [nnr_pkg::PHASE_W-1:0]  prev_acc_q;
  logic                         wrap_owed_q;
  nnr_pkg::out_beat_t           owed_results_q[$];
  int unsigned                  errors;

  // Resample one sample beat and queue the beats it should produce.
  task automatic resample_beat(input nnr_pkg::in_beat_t smp);
    nnr_pkg::out_beat_t           run_q[$];
    nnr_pkg::out_beat_t           pick;
    logic [nnr_pkg::PHASE_W-1:0]  eff_step;
    pick.out_real    = smp.in_real;
    pick.out_imag    = smp.in_imag;
    pick.last_of_run = 1'b0;
    if (!interp_q) begin
      wrap_owed_q = 1'b0;
      if (acc_q <= prev_acc_q) run_q.push_back(pick);
      prev_acc_q = acc_q;
      acc_q      = acc_q + step_q;
    end else begin
      eff_step = (step_q < STEP_FLOOR) ? STEP_FLOOR : step_q;
      if (wrap_owed_q) begin
        run_q.push_back(pick);
        wrap_owed_q = 1'b0;
      end
      while (run_q.size() < nnr_pkg::MAX_RUN) begin
        prev_acc_q = acc_q;
        acc_q      = acc_q + eff_step;
        if (acc_q <= prev_acc_q) begin
          wrap_owed_q = 1'b1;
          break;
        end
        run_q.push_back(pick);
      end
    end
    // flag the closing beat of the run
    if (run_q.size() > 0) begin
      pick = run_q.pop_back();
      pick.last_of_run = 1'b1;
      run_q.push_back(pick);
    end
    foreach (run_q[k]) owed_results_q.push_back(run_q[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nnr_pkg::out_beat_t want;
    if (!rst_ni) begin
      interp_q    = 1'b0;
      step_q      = '0;
      acc_q       = '0;
      prev_acc_q  = '0;
      wrap_owed_q = 1'b0;
      owed_results_q.delete();
      errors      = 0;
      error_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[nnr_pkg::APB_ADDR_W-1:2])
          nnr_pkg::REG_INTERPOLATE_MODE: interp_q = pwdata_i[0];
          nnr_pkg::REG_PHASE_STEP:       step_q   = pwdata_i[nnr_pkg::PHASE_W-1:0];
          default: ;
        endcase
      end
      if (sample_valid_i && sample_ready_i) resample_beat(sample_data_i);
      if (result_valid_i && result_ready_i) begin
        if (owed_results_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result beat re=%0d im=%0d last=%0b", $realtime,
                     result_data_i.out_real, result_data_i.out_imag,
                     result_data_i.last_of_run);
        end else begin
          want = owed_results_q.pop_front();
          if (result_data_i.out_real !== want.out_real ||
              result_data_i.out_imag !== want.out_imag ||
              result_data_i.last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: result mismatch: expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                       $realtime, want.out_real, want.out_imag, want.last_of_run,
                       result_data_i.out_real, result_data_i.out_imag,
                       result_data_i.last_of_run);
          end
        end
      end
      error_count_o <= errors;
      outstanding_o <= owed_results_q.size();
    end
  end

endmodule

>>> tb/nearest_neighbor_resampler_unit_tb.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_resampler_unit_tb
// Drives corner-value and random I/Q samples through the resampler in both
// decimate and interpolate modes over a range of phase steps, with random
// gaps on the sample side and random backpressure on the result side. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_neighbor_resampler_unit_tb;

  localparam int unsigned DRAIN_CYCLES   = 80;    // covers a full 64-beat run plus slack
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 11;
  localparam int unsigned PHASE_ITEMS    = 30;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  nnr_pkg::in_beat_t               in_data_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  nnr_pkg::out_beat_t              out_data_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [nnr_pkg::APB_ADDR_W-1:0]  paddr;
  logic [nnr_pkg::APB_DATA_W-1:0]  pwdata;
  logic [nnr_pkg::APB_DATA_W-1:0]  prdata;
  logic                            pready;

  int unsigned                     error_count;
  int unsigned                     outstanding;
  bit                              idle_en;
  int unsigned                     quiet_cycles;

  nearest_neighbor_resampler_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  nearest_neighbor_resampler_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (in_valid_i),
    .sample_ready_i (in_ready_o),
    .sample_data_i  (in_data_i),
    .result_valid_i (out_valid_o),
    .result_ready_i (out_ready_i),
    .result_data_i  (out_data_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .error_count_o  (error_count),
    .outstanding_o  (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: count cycles in which no beat and no register write completes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // Result-side backpressure: drop ready in random bursts.
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_en && rst_ni && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Pick corner sample values: both extremes, zero, minus one, plus one.
  function automatic logic [nnr_pkg::SAMPLE_BITS-1:0] corner(input int unsigned k);
    case (k % 5)
      0:       corner = 16'h7FFF;
      1:       corner = 16'h8000;
      2:       corner = 16'h0000;
      3:       corner = 16'hFFFF;
      default: corner = 16'h0001;
    endcase
  endfunction

  // Present one sample beat, hold it until accepted, then maybe idle a while.
  task automatic send_sample(input logic [nnr_pkg::SAMPLE_BITS-1:0] re,
                             input logic [nnr_pkg::SAMPLE_BITS-1:0] im);
    nnr_pkg::in_beat_t smp;
    smp.in_real = re;
    smp.in_imag = im;
    in_valid_i <= 1'b1;
    in_data_i  <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // One APB write: setup cycle, then access cycle.
  task automatic write_reg(input logic [nnr_pkg::APB_ADDR_W-3:0] idx,
                           input logic [nnr_pkg::APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain all owed results, then give a silent run time to finish.
  // Wait for the next clock edge first so the count includes the last accepted beat.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic interp, input logic [31:0] step);
    settle();
    write_reg(nnr_pkg::REG_INTERPOLATE_MODE, {31'b0, interp});
    write_reg(nnr_pkg::REG_PHASE_STEP, step);
  endtask

  task automatic send_corners(input int unsigned count, input int unsigned offset);
    for (int unsigned k = 0; k < count; k++)
      send_sample(corner(k + offset), corner(k + offset + 1));
  endtask

  initial begin
    logic        interp;
    logic [31:0] step;
    idle_en    = 1'b1;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pass-through on the reset settings.
    send_corners(4, 0);
    // Decimate by two.
    configure(1'b0, 32'h8000_0000);
    send_corners(4, 1);
    // Interpolate with a zero step: clamp to the floor, runs of up to 64 beats.
    configure(1'b1, 32'h0000_0000);
    send_corners(2, 2);
    // Interpolate with the largest step: every step wraps, so the first
    // sample yields nothing and each later one yields only its owed beat.
    configure(1'b1, 32'hFFFF_FFFF);
    send_corners(4, 3);
    // Interpolate by four; ends with a wrap owed.
    configure(1'b1, 32'h4000_0000);
    send_corners(3, 4);
    // Switch to decimate while a wrap is owed: drop the owed beat.
    configure(1'b0, 32'hFFFF_FFFF);
    send_corners(3, 0);
    // Step just under the floor and exactly at it.
    configure(1'b1, 32'h03FF_FFFF);
    send_corners(1, 1);
    configure(1'b1, 32'h0400_0000);
    send_corners(1, 2);

    // Random phases: random settings, random samples.
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 7))
        0: begin interp = 1'b0; step = 32'h0000_0000; end
        1: begin interp = 1'b0; step = $urandom; end
        2: begin interp = 1'b0; step = 32'hFFFF_FFFF; end
        3: begin interp = 1'b1; step = $urandom; end
        4: begin interp = 1'b1; step = $urandom_range(32'h0400_0000, 32'hFFFF_FFFF); end
        5: begin interp = 1'b1; step = $urandom_range(0, 32'h03FF_FFFF); end
        6: begin interp = 1'b1; step = 32'hFFFF_FFFF; end
        default: begin interp = 1'b1; step = 32'h8000_0000; end
      endcase
      configure(interp, step);
      // keep the closing phases free of idling
      idle_en = (ph + 2 < RANDOM_PHASES) && ($urandom_range(0, 3) != 0);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++)
        send_sample(16'($urandom), 16'($urandom));
    end

    settle();
    if (error_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
